/* rtl/eal2tk_pkg.sv */
// Package for the early-abandon L2 top-k selector.
// Holds the sequencer state type; no dependencies.
package eal2tk_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_CMP,
        ST_INS_PLACE,
        ST_REF_RD,
        ST_REF_WAIT,
        ST_FL_NEXT,
        ST_FL_WAIT,
        ST_FL_OUT
    } t_state;

endpackage

/* rtl/early_abandon_l2_topk_select_top.sv */
// Top level of the early-abandon L2 top-k selector.
// Depends on eal2tk_pkg for the sequencer state type.
//
// Usage:
//   Input channel (i_valid / o_stall) carries sample pairs (opcode 0) and
//   flush items (opcode 1). Output channel (o_valid / i_stall) carries the
//   ranked results of a flush. Config channel (i_cfg_valid / o_cfg_ready)
//   writes result_count; it is always ready and must be used while idle.
// Flow:
//   Sample pairs stream at one per cycle, while o_stall is low, through a
//   square stage and an accumulate stage. A final sample that enters the
//   kept set is placed by shifting back each kept entry that sorts after it:
//   the sorted store is one memory with a registered read, and insertion
//   shifts one entry per cycle. A final sample or flush stalls the input.
//   A flush emits k results, reading the store for each filled slot, plus
//   waiting on the receiver. No result is produced by a sample.
// Reset:
//   Clears the store count, running sum, abandon flag and sequencer; sets
//   result_count to 1. The memory itself is not cleared.
// Stall:
//   A stalled result holds on the output register; the sequencer waits and
//   the input channel stays stalled until the flush completes.
module early_abandon_l2_topk_select_top
    import eal2tk_pkg::*;
#(
    parameter int MAX_K       = 32,
    parameter int SAMPLE_BITS = 16,
    parameter int SUM_BITS    = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_opcode,
    input  logic signed [SAMPLE_BITS-1:0] i_query_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_candidate_sample,
    input  logic [31:0]                   i_candidate_id,
    input  logic                          i_last_sample,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [4:0]                    o_rank,
    output logic [31:0]                   o_result_id,
    output logic [SUM_BITS-1:0]           o_result_distance,
    output logic                          o_slot_filled,
    output logic                          o_last_result,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [5:0]                    i_cfg_data
);

    localparam int KW   = $clog2(MAX_K + 1);
    localparam int AW   = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int DW   = SAMPLE_BITS + 1;
    localparam int SQW  = 2 * DW;
    localparam int ACW  = ((SQW > SUM_BITS) ? SQW : SUM_BITS) + 1;
    localparam int EW   = SUM_BITS + 32;

    // configuration
    logic [5:0]    r_cfg;
    logic [KW-1:0] k_eff;

    // square stage
    logic           r_a_valid;
    logic           r_a_op;
    logic           r_a_last;
    logic [31:0]    r_a_id;
    logic [SQW-1:0] r_a_sq;
    logic signed [DW-1:0] diff;
    logic [DW-1:0]  mag;

    // accumulator and store state
    logic [SUM_BITS-1:0] r_sum, n_sum;
    logic                r_abandoned, n_abandoned;
    logic [KW-1:0]       r_cnt, n_cnt;
    logic [SUM_BITS-1:0] r_last_dist, n_last_dist;
    logic [SUM_BITS-1:0] worst;
    logic [ACW-1:0]      sum_ext;
    logic [SUM_BITS-1:0] sum_new;

    // sequencer
    t_state              r_state, n_state;
    logic [AW-1:0]       r_idx, n_idx;
    logic [KW-1:0]       r_newcnt, n_newcnt;
    logic [SUM_BITS-1:0] r_ins_d, n_ins_d;
    logic [31:0]         r_ins_id, n_ins_id;
    logic [AW-1:0]       r_place, n_place;
    logic [KW-1:0]       r_rank, n_rank;

    // output register
    logic                r_out_valid, n_out_valid;
    logic [4:0]          r_out_rank, n_out_rank;
    logic [31:0]         r_out_id, n_out_id;
    logic [SUM_BITS-1:0] r_out_dist, n_out_dist;
    logic                r_out_filled, n_out_filled;
    logic                r_out_last, n_out_last;

    // memory
    logic [EW-1:0]  r_mem [MAX_K];
    logic [EW-1:0]  r_rdata;
    logic           rd_en, w_en;
    logic [AW-1:0]  rd_addr, w_addr;
    logic [EW-1:0]  w_data;

    logic                in_xfer;
    logic [SUM_BITS-1:0] e_dist;
    logic [31:0]         e_id;
    logic                e_after;
    logic [KW-1:0]       idx_p1;
    logic [SUM_BITS-1:0] d_final;

    always_comb begin
        if (r_cfg == 6'd0) begin
            k_eff = KW'(1);
        end else if ({1'b0, r_cfg} > 7'(MAX_K)) begin
            k_eff = KW'(MAX_K);
        end else begin
            k_eff = KW'(r_cfg);
        end
    end

    assign worst = (r_cnt >= k_eff) ? r_last_dist : '1;

    assign o_stall     = (r_state != ST_IDLE) || (r_a_valid && (r_a_last || r_a_op));
    assign in_xfer     = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    assign diff = DW'(i_query_sample) - DW'(i_candidate_sample);
    assign mag  = diff[DW-1] ? DW'(-diff) : DW'(diff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg     <= 6'd1;
            r_a_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_data;
            end
            r_a_valid <= in_xfer;
        end
        if (in_xfer) begin
            r_a_op   <= i_opcode;
            r_a_last <= i_last_sample;
            r_a_id   <= i_candidate_id;
            r_a_sq   <= SQW'(mag) * SQW'(mag);
        end
    end

    assign sum_ext = ACW'(r_sum) + ACW'(r_a_sq);
    assign sum_new = (sum_ext > ACW'({SUM_BITS{1'b1}})) ? '1 : sum_ext[SUM_BITS-1:0];
    assign d_final = r_abandoned ? r_sum : sum_new;

    assign e_dist  = r_rdata[EW-1:32];
    assign e_id    = r_rdata[31:0];
    assign e_after = (e_dist > r_ins_d) || ((e_dist == r_ins_d) && (e_id > r_ins_id));
    assign idx_p1  = KW'(r_idx) + KW'(1);

    always_comb begin
        n_state      = r_state;
        n_sum        = r_sum;
        n_abandoned  = r_abandoned;
        n_cnt        = r_cnt;
        n_last_dist  = r_last_dist;
        n_idx        = r_idx;
        n_newcnt     = r_newcnt;
        n_ins_d      = r_ins_d;
        n_ins_id     = r_ins_id;
        n_place      = r_place;
        n_rank       = r_rank;
        n_out_valid  = r_out_valid;
        n_out_rank   = r_out_rank;
        n_out_id     = r_out_id;
        n_out_dist   = r_out_dist;
        n_out_filled = r_out_filled;
        n_out_last   = r_out_last;
        rd_en        = 1'b0;
        rd_addr      = r_idx;
        w_en         = 1'b0;
        w_addr       = r_idx;
        w_data       = r_rdata;

        unique case (r_state)
            ST_IDLE: begin
                if (r_a_valid) begin
                    if (r_a_op) begin
                        n_sum       = '0;
                        n_abandoned = 1'b0;
                        n_rank      = '0;
                        n_state     = ST_FL_NEXT;
                    end else if (!r_a_last) begin
                        if (!r_abandoned) begin
                            n_sum       = sum_new;
                            n_abandoned = (sum_new >= worst);
                        end
                    end else begin
                        n_sum       = '0;
                        n_abandoned = 1'b0;
                        if ((r_cnt < k_eff) || (d_final < worst)) begin
                            n_ins_d  = d_final;
                            n_ins_id = r_a_id;
                            n_newcnt = (r_cnt < k_eff) ? KW'(r_cnt + KW'(1)) : k_eff;
                            if (r_cnt == '0) begin
                                n_place = '0;
                                n_state = ST_INS_PLACE;
                            end else begin
                                n_idx   = AW'(r_cnt - KW'(1));
                                rd_en   = 1'b1;
                                rd_addr = AW'(r_cnt - KW'(1));
                                n_state = ST_INS_CMP;
                            end
                        end
                    end
                end
            end
            ST_INS_CMP: begin
                if (e_after) begin
                    if (idx_p1 < r_newcnt) begin
                        w_en   = 1'b1;
                        w_addr = AW'(idx_p1);
                        w_data = r_rdata;
                    end
                    if (r_idx == '0) begin
                        n_place = '0;
                        n_state = ST_INS_PLACE;
                    end else begin
                        n_idx   = r_idx - AW'(1);
                        rd_en   = 1'b1;
                        rd_addr = r_idx - AW'(1);
                    end
                end else begin
                    if (idx_p1 < r_newcnt) begin
                        w_en   = 1'b1;
                        w_addr = AW'(idx_p1);
                        w_data = {r_ins_d, r_ins_id};
                    end
                    n_state = ST_REF_RD;
                end
            end
            ST_INS_PLACE: begin
                w_en    = 1'b1;
                w_addr  = r_place;
                w_data  = {r_ins_d, r_ins_id};
                n_state = ST_REF_RD;
            end
            ST_REF_RD: begin
                rd_en   = 1'b1;
                rd_addr = AW'(r_newcnt - KW'(1));
                n_state = ST_REF_WAIT;
            end
            ST_REF_WAIT: begin
                n_last_dist = e_dist;
                n_cnt       = r_newcnt;
                n_state     = ST_IDLE;
            end
            ST_FL_NEXT: begin
                if (r_rank < r_cnt) begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(r_rank);
                    n_state = ST_FL_WAIT;
                end else begin
                    n_out_valid  = 1'b1;
                    n_out_rank   = 5'(r_rank);
                    n_out_id     = '0;
                    n_out_dist   = '1;
                    n_out_filled = 1'b0;
                    n_out_last   = (r_rank == KW'(k_eff - KW'(1)));
                    n_state      = ST_FL_OUT;
                end
            end
            ST_FL_WAIT: begin
                n_out_valid  = 1'b1;
                n_out_rank   = 5'(r_rank);
                n_out_id     = e_id;
                n_out_dist   = e_dist;
                n_out_filled = 1'b1;
                n_out_last   = (r_rank == KW'(k_eff - KW'(1)));
                n_state      = ST_FL_OUT;
            end
            ST_FL_OUT: begin
                if (!i_stall) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        n_cnt   = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_rank  = r_rank + KW'(1);
                        n_state = ST_FL_NEXT;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sum       <= '0;
            r_abandoned <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_abandoned <= n_abandoned;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_last_dist  <= n_last_dist;
        r_idx        <= n_idx;
        r_newcnt     <= n_newcnt;
        r_ins_d      <= n_ins_d;
        r_ins_id     <= n_ins_id;
        r_place      <= n_place;
        r_rank       <= n_rank;
        r_out_rank   <= n_out_rank;
        r_out_id     <= n_out_id;
        r_out_dist   <= n_out_dist;
        r_out_filled <= n_out_filled;
        r_out_last   <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    assign o_valid           = r_out_valid;
    assign o_rank            = r_out_rank;
    assign o_result_id       = r_out_id;
    assign o_result_distance = r_out_dist;
    assign o_slot_filled     = r_out_filled;
    assign o_last_result     = r_out_last;

endmodule

/* test/tb_early_abandon_l2_topk_select_top.sv */
// Testbench for the early-abandon L2 top-k selector: streams candidates and flushes,
// predicts ranked results with its own k-nearest model, checks every result transfer.
// Depends on early_abandon_l2_topk_select_top and eal2tk_pkg.
`timescale 1ns / 1ps

module tb_early_abandon_l2_topk_select_top;
    import eal2tk_pkg::*;

    localparam int MAX_K = 32;
    localparam logic [47:0] DIST_ALL_ONES = '1;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic [4:0]  rank;
        logic [31:0] id;
        logic [47:0] distance;
        logic        filled;
        logic        last;
    } t_ranked;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic i_opcode = 1'b0;
    logic signed [15:0] i_query_sample = '0;
    logic signed [15:0] i_candidate_sample = '0;
    logic [31:0] i_candidate_id = '0;
    logic i_last_sample = 1'b0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [4:0] o_rank;
    logic [31:0] o_result_id;
    logic [47:0] o_result_distance;
    logic o_slot_filled;
    logic o_last_result;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [5:0] i_cfg_data = '0;

    early_abandon_l2_topk_select_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_opcode(i_opcode),
        .i_query_sample(i_query_sample), .i_candidate_sample(i_candidate_sample),
        .i_candidate_id(i_candidate_id), .i_last_sample(i_last_sample),
        .o_valid(o_valid), .i_stall(i_stall), .o_rank(o_rank),
        .o_result_id(o_result_id), .o_result_distance(o_result_distance),
        .o_slot_filled(o_slot_filled), .o_last_result(o_last_result),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // nearest-neighbor model state
    logic [5:0]  k_reg;
    logic [47:0] acc_sum;
    logic        acc_frozen;
    logic [47:0] near_dist[MAX_K+1];
    logic [31:0] near_id[MAX_K+1];
    int          near_cnt;
    logic [47:0] worst_dist;

    t_ranked exp_results[$];
    int      errors = 0;
    int      items_sent = 0;
    int      results_seen = 0;
    int      flushes_sent = 0;
    bit      quiet = 1'b0;
    int      idle_cycles = 0;
    int      stall_left = 0;

    function automatic int eff_k();
        if (k_reg == 0) return 1;
        if (k_reg > MAX_K) return MAX_K;
        return int'(k_reg);
    endfunction

    function automatic bit ranks_after(int a, int b);
        if (near_dist[a] != near_dist[b]) return near_dist[a] > near_dist[b];
        return near_id[a] > near_id[b];
    endfunction

    function automatic int worst_slot();
        int w;
        w = 0;
        for (int i = 1; i < near_cnt; i++)
            if (ranks_after(i, w)) w = i;
        return w;
    endfunction

    function automatic void refresh_worst();
        if (near_cnt >= eff_k() && near_cnt > 0) worst_dist = near_dist[worst_slot()];
        else worst_dist = DIST_ALL_ONES;
    endfunction

    function automatic void model_reset();
        k_reg = 6'd1;
        acc_sum = '0;
        acc_frozen = 1'b0;
        near_cnt = 0;
        worst_dist = DIST_ALL_ONES;
    endfunction

    function automatic void complete_candidate(logic [31:0] id);
        int w;
        if (near_cnt < eff_k() || acc_sum < worst_dist) begin
            near_dist[near_cnt] = acc_sum;
            near_id[near_cnt] = id;
            near_cnt++;
            while (near_cnt > eff_k()) begin
                w = worst_slot();
                near_cnt--;
                near_dist[w] = near_dist[near_cnt];
                near_id[w] = near_id[near_cnt];
            end
        end
        refresh_worst();
        acc_sum = '0;
        acc_frozen = 1'b0;
    endfunction

    function automatic void predict_item(logic op, logic signed [15:0] q,
                                         logic signed [15:0] c, logic [31:0] id,
                                         logic last);
        longint diff;
        longint unsigned sq;
        longint unsigned total;
        int m;
        logic [47:0] td;
        logic [31:0] ti;
        t_ranked r;
        if (op == OP_SAMPLE) begin
            if (!acc_frozen) begin
                diff = longint'(q) - longint'(c);
                if (diff < 0) diff = -diff;
                sq = longint'(diff) * longint'(diff);
                total = 64'(acc_sum) + sq;
                acc_sum = (total > 64'(DIST_ALL_ONES)) ? DIST_ALL_ONES : total[47:0];
                if (acc_sum >= worst_dist) acc_frozen = 1'b1;
            end
            if (last) complete_candidate(id);
        end else begin
            for (int i = 0; i < near_cnt; i++) begin
                m = i;
                for (int j = i + 1; j < near_cnt; j++)
                    if (ranks_after(m, j)) m = j;
                td = near_dist[i]; ti = near_id[i];
                near_dist[i] = near_dist[m]; near_id[i] = near_id[m];
                near_dist[m] = td; near_id[m] = ti;
            end
            for (int i = 0; i < eff_k(); i++) begin
                r.rank = 5'(i);
                r.filled = (i < near_cnt);
                r.id = r.filled ? near_id[i] : 32'd0;
                r.distance = r.filled ? near_dist[i] : DIST_ALL_ONES;
                r.last = (i + 1 == eff_k());
                exp_results = {exp_results, r};
            end
            near_cnt = 0;
            acc_sum = '0;
            acc_frozen = 1'b0;
            worst_dist = DIST_ALL_ONES;
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_ranked e;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (exp_results.size() == 0) begin
                $display("%0t: unexpected result rank=%0d id=%0d", $realtime, o_rank,
                         o_result_id);
                errors++;
            end else begin
                e = exp_results.pop_front();
                if (e.rank !== o_rank || e.id !== o_result_id
                    || e.distance !== o_result_distance
                    || e.filled !== o_slot_filled || e.last !== o_last_result) begin
                    $display("%0t: mismatch exp rank=%0d id=%0d dist=%0d filled=%0b last=%0b",
                             $realtime, e.rank, e.id, e.distance, e.filled, e.last);
                    $display("%0t:          got rank=%0d id=%0d dist=%0d filled=%0b last=%0b",
                             $realtime, o_rank, o_result_id, o_result_distance,
                             o_slot_filled, o_last_result);
                    errors++;
                end
            end
        end
    end

    // receiver stall bursts
    always @(negedge i_clk) begin
        if (quiet || !i_rst_n) begin
            stall_left = 0;
            i_stall = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall = 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 14);
            i_stall = 1'b1;
        end else begin
            i_stall = 1'b0;
        end
    end

    // watchdog on transfers
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(logic op, logic signed [15:0] q, logic signed [15:0] c,
                             logic [31:0] id, logic last);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_opcode = op;
        i_query_sample = q;
        i_candidate_sample = c;
        i_candidate_id = id;
        i_last_sample = last;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        predict_item(op, q, c, id, last);
        items_sent++;
        if (op == OP_FLUSH) flushes_sent++;
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic send_candidate(logic [31:0] id, int len, int span);
        logic signed [15:0] q;
        for (int i = 0; i < len; i++) begin
            q = 16'($urandom);
            send_item(OP_SAMPLE, q, 16'(int'(q) + $urandom_range(0, span) - span / 2),
                      (i == len - 1) ? id : 32'($urandom), i == len - 1);
        end
    endtask

    task automatic send_flush();
        send_item(OP_FLUSH, 16'($urandom), 16'($urandom), 32'($urandom), 1'($urandom));
    endtask

    task automatic write_k(logic [5:0] v);
        wait (exp_results.size() == 0);
        repeat (60) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data = v;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        k_reg = v;
        refresh_worst();
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic test_extremes();
        send_item(OP_SAMPLE, 16'sh7FFF, 16'sh8000, 32'hFFFF_FFFF, 1'b1);
        send_item(OP_SAMPLE, 16'sh8000, 16'sh7FFF, 32'h0, 1'b1);
        send_item(OP_SAMPLE, 16'sh0000, 16'sh0000, 32'h5555_AAAA, 1'b0);
        send_item(OP_SAMPLE, 16'sh1234, 16'sh1234, 32'hAAAA_5555, 1'b1);
        send_flush();
        send_flush();
    endtask

    task automatic test_ties();
        write_k(6'd4);
        send_item(OP_SAMPLE, 16'sd10, 16'sd7, 32'd9, 1'b1);
        send_item(OP_SAMPLE, 16'sd3, 16'sd0, 32'd4, 1'b1);
        send_item(OP_SAMPLE, -16'sd3, 16'sd0, 32'd4, 1'b1);
        send_item(OP_SAMPLE, 16'sd0, 16'sd3, 32'd7, 1'b1);
        send_item(OP_SAMPLE, 16'sd0, 16'sd3, 32'd2, 1'b1);
        send_item(OP_SAMPLE, 16'sd100, 16'sd0, 32'd1, 1'b0);
        send_item(OP_SAMPLE, 16'sd100, 16'sd0, 32'd1, 1'b0);
        send_item(OP_SAMPLE, 16'sd0, 16'sd0, 32'd1, 1'b1);
        send_item(OP_SAMPLE, 16'sd1, 16'sd0, 32'd8, 1'b0);
        send_flush();
    endtask

    task automatic test_large_sums();
        for (int i = 0; i < 8; i++)
            send_item(OP_SAMPLE, 16'sh8000, 16'sh7FFF, 32'd77, i == 7);
        send_item(OP_SAMPLE, 16'sd5, 16'sd5, 32'd78, 1'b1);
        send_flush();
    endtask

    task automatic test_k_settings();
        logic [5:0] ks[4] = '{6'd32, 6'd63, 6'd0, 6'd6};
        foreach (ks[n]) begin
            write_k(ks[n]);
            for (int c = 0; c < $urandom_range(2, 10); c++)
                send_candidate(32'($urandom_range(0, 20)), $urandom_range(1, 4), 64);
            write_k(6'd2);
            send_candidate(32'($urandom), 2, 16);
            send_flush();
        end
    endtask

    task automatic test_random();
        int phase_items;
        for (int p = 0; p < 6; p++) begin
            if (p == 5) quiet = 1'b1;
            write_k(6'($urandom_range(1, 12)));
            phase_items = items_sent;
            while (items_sent - phase_items < 18) begin
                if ($urandom_range(0, 9) == 0) send_flush();
                else if ($urandom_range(0, 7) == 0)
                    send_item(OP_SAMPLE, 16'($urandom), 16'($urandom), 32'($urandom),
                              1'($urandom));
                else send_candidate(32'($urandom_range(0, 3)) << $urandom_range(0, 30),
                                    $urandom_range(1, 5), $urandom_range(0, 2) * 300);
            end
            if ($urandom_range(0, 1)) send_candidate(32'($urandom), 3, 1000);
            send_flush();
        end
    endtask

    initial begin
        model_reset();
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_extremes();
        test_ties();
        test_k_settings();
        test_large_sums();
        test_random();
        wait (exp_results.size() == 0);
        repeat (100) @(negedge i_clk);
        $display("Sent %0d items (%0d flushes) over k settings 0..63, ties, large sums;",
                 items_sent, flushes_sent);
        $display("checked %0d ranked results, %0d errors.", results_seen, errors);
        if (errors == 0 && exp_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/eal2tk_pkg.sv
rtl/early_abandon_l2_topk_select_top.sv
test/tb_early_abandon_l2_topk_select_top.sv
